FILE: rtl/core/pmfe_pkg.sv
`timescale 1ns / 1ps

package pmfe_pkg;

    localparam int BYTE_W         = 8;
    localparam int FIELD_COUNT_W  = 4;
    localparam int SLICE_W        = 6;
    localparam int WIDTH_TABLE_W  = 48;
    localparam int FIELD_VALUE_W  = 64;
    localparam int INDEX_W        = 3;
    localparam int KIND_W         = 2;
    localparam int REM_W          = 4;
    localparam int WIDTH_W        = 7;

    localparam int MAX_FIELDS     = 8;
    localparam int MAX_FIELD_BITS = 64;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_TABLE = 4'd1;

    localparam logic [KIND_W-1:0] KIND_FIELD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_packet;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [INDEX_W-1:0]       field_index;
        logic [FIELD_VALUE_W-1:0] field_value;
        logic [BYTE_W-1:0]        payload_byte;
        logic                     packet_last;
        logic                     run_end;
    } t_result;

    typedef struct packed {
        logic [FIELD_COUNT_W-1:0] field_count;
        logic [WIDTH_TABLE_W-1:0] width_table;
    } t_cfg;

endpackage

FILE: rtl/core/pmfe_if.sv
`timescale 1ns / 1ps

interface pmfe_in_if;
    logic                           valid;
    logic                           ready;
    logic [pmfe_pkg::BYTE_W-1:0]    data_byte;
    logic                           end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface pmfe_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [pmfe_pkg::KIND_W-1:0]          kind;
    logic [pmfe_pkg::INDEX_W-1:0]         field_index;
    logic [pmfe_pkg::FIELD_VALUE_W-1:0]   field_value;
    logic [pmfe_pkg::BYTE_W-1:0]          payload_byte;
    logic                                 packet_last;
    logic                                 run_end;

    modport source (output valid, output kind, output field_index, output field_value,
                    output payload_byte, output packet_last, output run_end, input ready);
    modport sink   (input valid, input kind, input field_index, input field_value,
                    input payload_byte, input packet_last, input run_end, output ready);
endinterface

interface pmfe_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pmfe_pkg::CFG_INDEX_W-1:0]   index;
    logic [pmfe_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/pmfe_front.sv
`timescale 1ns / 1ps

module pmfe_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pmfe_in_if.sink            i_in,
    output pmfe_pkg::t_in_word o_head,
    output logic               o_head_valid,
    input  logic               i_pop
);
    localparam int DEPTH = pmfe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pmfe_pkg::t_in_word r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    pmfe_pkg::t_in_word in_word;

    assign i_in.ready   = (r_count != CNT_W'(DEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        in_word.data_byte     = i_in.data_byte;
        in_word.end_of_packet = i_in.end_of_packet;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/pmfe_back.sv
`timescale 1ns / 1ps

module pmfe_back #(
    parameter int MAX_FIELD_BITS = pmfe_pkg::MAX_FIELD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmfe_pkg::t_cfg     i_cfg,
    input  pmfe_pkg::t_in_word i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    pmfe_out_if.source         o_out
);
    localparam int BW    = $clog2(MAX_FIELD_BITS + 1);
    localparam int REM_W = pmfe_pkg::REM_W;
    localparam int WW    = pmfe_pkg::WIDTH_W;
    localparam int FCW   = pmfe_pkg::FIELD_COUNT_W;

    function automatic logic [WW-1:0] width_of(
        input logic [pmfe_pkg::WIDTH_TABLE_W-1:0] tbl,
        input logic [pmfe_pkg::INDEX_W-1:0]       idx
    );
        logic [WW-1:0] w;
        w = WW'(tbl[idx * pmfe_pkg::SLICE_W +: pmfe_pkg::SLICE_W]) + WW'(1);
        if (w > WW'(MAX_FIELD_BITS)) begin
            w = WW'(MAX_FIELD_BITS);
        end
        return w;
    endfunction

    logic                          r_busy;
    logic [pmfe_pkg::BYTE_W-1:0]   r_byte;
    logic [REM_W-1:0]              r_rem;
    logic                          r_eop;
    logic [FCW-1:0]                r_field;
    logic [BW-1:0]                 r_bits;
    logic [MAX_FIELD_BITS-1:0]     r_acc;
    logic                          r_out_valid;
    pmfe_pkg::t_result             r_out;

    logic [FCW-1:0]                nf;
    logic                          hdr;
    logic [BW-1:0]                 w_cur;
    logic [BW-1:0]                 need;
    logic                          fits;
    logic [REM_W-1:0]              take;
    logic [pmfe_pkg::BYTE_W-1:0]   top_bits;
    logic [MAX_FIELD_BITS-1:0]     n_acc;
    logic [FCW-1:0]                n_field;
    logic [REM_W-1:0]              n_rem;
    logic [BW-1:0]                 w_next;
    logic [pmfe_pkg::BYTE_W-1:0]   shifted;
    logic [pmfe_pkg::BYTE_W-1:0]   rest;
    logic                          carry;
    logic                          more;
    logic                          emit;
    logic                          done;
    logic                          slot_free;
    logic                          step;
    logic                          load;
    pmfe_pkg::t_result             res;

    assign nf = (i_cfg.field_count > FCW'(pmfe_pkg::MAX_FIELDS))
              ? FCW'(pmfe_pkg::MAX_FIELDS) : i_cfg.field_count;
    assign hdr   = (r_field < nf);
    assign w_cur = BW'(width_of(i_cfg.width_table, r_field[pmfe_pkg::INDEX_W-1:0]));
    // bits already past the width (table rewritten mid-field) complete on the next bit
    assign need  = (r_bits >= w_cur) ? BW'(1) : w_cur - r_bits;
    assign fits  = (need <= BW'(r_rem));
    assign take  = fits ? REM_W'(need) : r_rem;
    assign top_bits = pmfe_pkg::BYTE_W'(r_byte >> (REM_W'(pmfe_pkg::BYTE_W) - take));
    assign n_acc    = (r_acc << take) | MAX_FIELD_BITS'(top_bits);
    assign n_field  = r_field + 1'b1;
    assign n_rem    = r_rem - take;
    assign w_next   = BW'(width_of(i_cfg.width_table, n_field[pmfe_pkg::INDEX_W-1:0]));
    assign shifted  = r_byte << take;
    assign rest     = shifted >> (REM_W'(pmfe_pkg::BYTE_W) - n_rem);
    assign more     = hdr && fits && (n_field < nf) && (r_eop || (w_next <= BW'(n_rem)));
    assign carry    = !more && (n_field < nf);
    assign emit     = !hdr || fits || r_eop;
    assign done     = !more;
    assign slot_free = !r_out_valid || o_out.ready;
    assign step      = r_busy && (!emit || slot_free);
    assign load      = (!r_busy || (step && done)) && i_head_valid;
    assign o_pop     = load;

    always_comb begin
        res = '0;
        if (!hdr) begin
            res.kind         = pmfe_pkg::KIND_PAYLOAD;
            res.payload_byte = r_byte;
            res.run_end      = 1'b1;
            res.packet_last  = r_eop;
        end else if (fits) begin
            res.kind        = pmfe_pkg::KIND_FIELD;
            res.field_index = r_field[pmfe_pkg::INDEX_W-1:0];
            res.field_value = pmfe_pkg::FIELD_VALUE_W'(n_acc);
            res.run_end     = !more;
            res.packet_last = r_eop && !more;
        end else begin
            res.kind        = pmfe_pkg::KIND_DROP;
            res.run_end     = 1'b1;
            res.packet_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.data_byte;
            r_rem  <= REM_W'(pmfe_pkg::BYTE_W);
            r_eop  <= i_head.end_of_packet;
        end else if (step && hdr && fits) begin
            r_byte <= r_byte << take;
            r_rem  <= n_rem;
        end
        if (step && emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_field     <= '0;
            r_bits      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (step && done) begin
                r_busy <= 1'b0;
            end

            if (step) begin
                if (done && r_eop) begin
                    r_field <= '0;
                    r_bits  <= '0;
                    r_acc   <= '0;
                end else if (hdr && fits) begin
                    r_field <= n_field;
                    // leftover bits of the word start the next field
                    r_bits  <= carry ? BW'(n_rem) : '0;
                    r_acc   <= carry ? MAX_FIELD_BITS'(rest) : '0;
                end else if (hdr) begin
                    r_bits <= r_bits + BW'(r_rem);
                    r_acc  <= n_acc;
                end
            end

            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.field_index  = r_out.field_index;
    assign o_out.field_value  = r_out.field_value;
    assign o_out.payload_byte = r_out.payload_byte;
    assign o_out.packet_last  = r_out.packet_last;
    assign o_out.run_end      = r_out.run_end;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && emit && res.packet_last |=> (r_field == '0) && (r_bits == '0))
        else $error("packet state not cleared after packet end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && emit && (res.kind == pmfe_pkg::KIND_DROP) |-> r_eop && hdr)
        else $error("drop outside a short packet");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem <= REM_W'(pmfe_pkg::BYTE_W)))
        else $error("bit count of held byte out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && emit && res.packet_last |-> res.run_end && r_eop)
        else $error("packet end flag without run end");

endmodule

FILE: rtl/core/packet_metadata_field_extractor_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Protocol     Payload
// i_in     in   valid/ready  data_byte[7:0], end_of_packet
// o_out    out  valid/ready  kind[1:0], field_index[2:0], field_value[63:0],
//                            payload_byte[7:0], packet_last, run_end
// i_cfg    in   valid/ready  index[3:0] (0 field_count, 1 width_table), data[47:0]
//
// One byte per cycle while o_out is not stalled; a header byte that completes several
// fields (plus a drop word on a short packet) is held for the one-step-per-cycle field
// extractor. Input goes via queue, held-byte and output registers to its first result.
// Synchronous active-low reset clears the queue, packet state and both registers.
// A 4-word queue decouples input from the extractor; i_cfg is always ready.

module packet_metadata_field_extractor_core #(
    parameter int MAX_FIELD_BITS = pmfe_pkg::MAX_FIELD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmfe_in_if.sink    i_in,
    pmfe_out_if.source o_out,
    pmfe_cfg_if.sink   i_cfg
);
    logic [pmfe_pkg::FIELD_COUNT_W-1:0] r_field_count;
    logic [pmfe_pkg::WIDTH_TABLE_W-1:0] r_width_table;
    pmfe_pkg::t_cfg                     cfg;
    pmfe_pkg::t_in_word                 head;
    logic                               head_valid;
    logic                               pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= '0;
            r_width_table <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                pmfe_pkg::CFG_FIELD_COUNT: begin
                    r_field_count <= i_cfg.data[pmfe_pkg::FIELD_COUNT_W-1:0];
                end
                pmfe_pkg::CFG_WIDTH_TABLE: begin
                    r_width_table <= i_cfg.data[pmfe_pkg::WIDTH_TABLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.field_count = r_field_count;
        cfg.width_table = r_width_table;
    end

    pmfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    pmfe_back #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
